@@ hdl/u8vc_pkg.sv @@
// Package: shared types, character codes and the per-byte UTF-8 check.
`default_nettype none
package u8vc_pkg;

  localparam logic [7:0]  ChLf       = 8'h0A;
  localparam logic [7:0]  ChTab      = 8'h09;
  localparam logic [7:0]  ChCr       = 8'h0D;
  localparam logic [7:0]  ChDel      = 8'h7F;
  localparam logic [7:0]  CtlLimit   = 8'h20;
  localparam logic [7:0]  Lead2Mask  = 8'hE0;
  localparam logic [7:0]  Lead2Code  = 8'hC0;
  localparam logic [7:0]  Lead3Mask  = 8'hF0;
  localparam logic [7:0]  Lead3Code  = 8'hE0;
  localparam logic [7:0]  Lead4Mask  = 8'hF8;
  localparam logic [7:0]  Lead4Code  = 8'hF0;
  localparam logic [20:0] Min3Byte   = 21'h000800;
  localparam logic [20:0] Min4Byte   = 21'h010000;
  localparam logic [20:0] SurrLow    = 21'h00D800;
  localparam logic [20:0] SurrHigh   = 21'h00DFFF;
  localparam logic [20:0] MaxCode    = 21'h10FFFF;

  // Decoder state carried between bytes.
  typedef struct packed {
    logic [1:0]  rem;
    logic [2:0]  seqlen;
    logic [20:0] cp;
  } dec_t;

  typedef struct packed {
    logic ok;
    dec_t dec;
  } chk_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       stream_end;
    logic       status;
  } res_t;

  localparam dec_t DecIdle = '{rem: 2'd0, seqlen: 3'd0, cp: 21'd0};

  // Advance the decoder by one normalized byte; ok is low on a UTF-8 error.
  function automatic chk_t check_byte(dec_t d, logic [7:0] v, logic fin);
    chk_t c;
    logic [20:0] cp;
    c.ok  = 1'b1;
    c.dec = d;
    cp    = d.cp;
    if (d.rem == 2'd0) begin
      if (v == 8'h00 || (v < CtlLimit && v != ChLf && v != ChTab) || v == ChDel) begin
        c.ok = 1'b0;
      end else if (!v[7]) begin
        c.dec.seqlen = 3'd1;
        c.dec.cp     = {13'd0, v};
      end else if ((v & Lead2Mask) == Lead2Code) begin
        c.dec.cp     = {16'd0, v[4:0]};
        c.dec.seqlen = 3'd2;
        c.dec.rem    = 2'd1;
        if (v[4:1] == 4'd0) c.ok = 1'b0;
      end else if ((v & Lead3Mask) == Lead3Code) begin
        c.dec.cp     = {17'd0, v[3:0]};
        c.dec.seqlen = 3'd3;
        c.dec.rem    = 2'd2;
      end else if ((v & Lead4Mask) == Lead4Code) begin
        c.dec.cp     = {18'd0, v[2:0]};
        c.dec.seqlen = 3'd4;
        c.dec.rem    = 2'd3;
      end else begin
        c.ok = 1'b0;
      end
    end else begin
      if (v[7:6] != 2'b10) begin
        c.ok = 1'b0;
      end else begin
        cp        = {d.cp[14:0], v[5:0]};
        c.dec.cp  = cp;
        c.dec.rem = d.rem - 2'd1;
        if (c.dec.rem == 2'd0) begin
          if ((d.seqlen == 3'd3 && cp < Min3Byte) ||
              (d.seqlen == 3'd4 && cp < Min4Byte) ||
              (cp >= SurrLow && cp <= SurrHigh) || cp > MaxCode) begin
            c.ok = 1'b0;
          end
        end
      end
    end
    // A final byte must not leave a sequence open.
    if (c.ok && fin && c.dec.rem != 2'd0) c.ok = 1'b0;
    return c;
  endfunction

  function automatic res_t norm_result(logic ok, logic [7:0] v, logic fin);
    res_t r;
    r.out_byte     = ok ? v : 8'h00;
    r.byte_present = ok;
    r.stream_end   = fin;
    r.status       = !ok;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/u8vc_in_if.sv @@
// Interface: input byte channel with valid/ready handshake.
`default_nettype none
interface u8vc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/u8vc_out_if.sv @@
// Interface: result channel with valid/ready handshake.
`default_nettype none
interface u8vc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       stream_end;
  logic       status;

  modport source (output valid, output out_byte, output byte_present,
                  output stream_end, output status, input ready);
  modport sink   (input valid, input out_byte, input byte_present,
                  input stream_end, input status, output ready);
endinterface
`default_nettype wire

@@ hdl/utf8_validate_crlf_normalize.sv @@
// Top level: UTF-8 validator with CR/LF normalization and a result queue.
//
//  channel     dir  payload                                      handshake
//  text_in     in   text_byte[8], last_byte                      valid/ready
//  result_out  out  out_byte[8], byte_present, stream_end,        valid/ready
//                   status
//
// Each accepted byte is decoded in the cycle it is taken and its 0..2 results
// go into a 3-entry result queue; the first result is visible in the next cycle.
// Sustained rate is one byte per cycle while result_out is ready; a held CR
// followed by a byte other than LF can yield two results, and the queue
// drains one result per cycle. text_in.ready is a register-only function of
// queue fill (at most one entry held). Reset (rst, synchronous) empties the
// queue and clears the decoder.
`default_nettype none
module utf8_validate_crlf_normalize (
  input  wire logic  clk,
  input  wire logic  rst,
  u8vc_in_if.sink    text_in,
  u8vc_out_if.source result_out
);

  // decoder state
  logic                pcr;
  logic                err;
  u8vc_pkg::dec_t      dec;
  logic                pcr_next;
  logic                err_next;
  u8vc_pkg::dec_t      dec_next;

  // result queue
  u8vc_pkg::res_t      q [3];
  logic [1:0]          wp;
  logic [1:0]          rp;
  logic [1:0]          count;

  logic                accept;
  logic                pop;
  logic [1:0]          n_res;
  u8vc_pkg::res_t      r0;
  u8vc_pkg::res_t      r1;

  logic [7:0]          b;
  logic                last;
  logic                run_a;
  logic                hold_cr;
  logic [7:0]          xb;
  u8vc_pkg::dec_t      dec_b;
  u8vc_pkg::chk_t      chk_a;
  u8vc_pkg::chk_t      chk_b;
  u8vc_pkg::res_t      res_b;
  u8vc_pkg::res_t      err_end;

  function automatic logic [1:0] inc3(logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign b      = text_in.text_byte;
  assign last   = text_in.last_byte;
  assign accept = text_in.valid && text_in.ready;
  assign pop    = result_out.valid && result_out.ready;

  assign text_in.ready = (count <= 2'd1);

  assign err_end = '{out_byte: 8'h00, byte_present: 1'b0, stream_end: 1'b1, status: 1'b1};

  // A held CR ahead of a byte other than LF is emitted as LF first.
  assign run_a   = pcr && (b != u8vc_pkg::ChLf);
  assign chk_a   = u8vc_pkg::check_byte(dec, u8vc_pkg::ChLf, 1'b0);
  assign dec_b   = run_a ? chk_a.dec : dec;
  assign hold_cr = (b == u8vc_pkg::ChCr) && !last;
  assign xb      = (b == u8vc_pkg::ChCr) ? u8vc_pkg::ChLf : b;
  assign chk_b   = u8vc_pkg::check_byte(dec_b, xb, last);
  assign res_b   = u8vc_pkg::norm_result(chk_b.ok, xb, last);

  always_comb begin
    n_res    = 2'd0;
    r0       = res_b;
    r1       = res_b;
    pcr_next = pcr;
    err_next = err;
    dec_next = dec;
    if (err) begin
      if (last) begin
        n_res = 2'd1;
        r0    = err_end;
      end
    end else begin
      pcr_next = 1'b0;
      if (run_a && !chk_a.ok) begin
        // drop the byte; close the stream if it was the final one
        n_res    = last ? 2'd2 : 2'd1;
        r0       = u8vc_pkg::norm_result(1'b0, u8vc_pkg::ChLf, 1'b0);
        r1       = err_end;
        err_next = 1'b1;
      end else begin
        if (run_a) begin
          r0       = u8vc_pkg::norm_result(1'b1, u8vc_pkg::ChLf, 1'b0);
          dec_next = chk_a.dec;
        end
        if (hold_cr) begin
          pcr_next = 1'b1;
          n_res    = run_a ? 2'd1 : 2'd0;
        end else begin
          n_res    = run_a ? 2'd2 : 2'd1;
          if (!run_a) r0 = res_b;
          dec_next = chk_b.dec;
          if (!chk_b.ok) err_next = 1'b1;
        end
      end
    end
    // A final byte returns everything to idle.
    if (last) begin
      pcr_next = 1'b0;
      err_next = 1'b0;
      dec_next = u8vc_pkg::DecIdle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcr <= 1'b0;
      err <= 1'b0;
      dec <= u8vc_pkg::DecIdle;
    end else if (accept) begin
      pcr <= pcr_next;
      err <= err_next;
      dec <= dec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 2'd0;
      rp    <= 2'd0;
      count <= 2'd0;
    end else begin
      if (accept) begin
        if (n_res == 2'd1) begin
          wp <= inc3(wp);
        end else if (n_res == 2'd2) begin
          wp <= inc3(inc3(wp));
        end
      end
      if (pop) rp <= inc3(rp);
      count <= count + (accept ? n_res : 2'd0) - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) q[wp] <= r0;
    if (accept && n_res == 2'd2) q[inc3(wp)] <= r1;
  end

  assign result_out.valid        = (count != 2'd0);
  assign result_out.out_byte     = q[rp].out_byte;
  assign result_out.byte_present = q[rp].byte_present;
  assign result_out.stream_end   = q[rp].stream_end;
  assign result_out.status       = q[rp].status;

  // A final byte leaves the decoder idle.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> !pcr && !err && dec.rem == 2'd0)
    else $error("decoder not idle after final byte");

  // A good result always carries a byte.
  a_good_has_byte: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.status |-> result_out.byte_present)
    else $error("valid-status result without a byte");

  // After an error no CR is held.
  a_err_no_cr: assert property (@(posedge clk) disable iff (rst)
    err |-> !pcr)
    else $error("CR held while stream is in error");

endmodule
`default_nettype wire

@@ tb/u8vc_scoreboard.sv @@
`timescale 1ns / 100ps
// Scoreboard: predicts normalized bytes and stream status from accepted text and checks results.
module u8vc_scoreboard (
  input  logic clk,
  input  logic rst,
  u8vc_in_if   text_mon,
  u8vc_out_if  res_mon,
  output int   fail_count,
  output int   pending,
  output int   dropped_bytes,
  output int   results_seen,
  output int   streams_seen,
  output int   bad_streams
);

  u8vc_pkg::res_t expected_results[$];

  logic        cr_held;
  logic [1:0]  need;
  logic [2:0]  seq_len;
  logic [20:0] acc;
  logic        bad_stream;

  function automatic void reset_decoder();
    cr_held    = 1'b0;
    need       = 2'd0;
    seq_len    = 3'd0;
    acc        = 21'd0;
    bad_stream = 1'b0;
  endfunction

  function automatic void push_expected(logic [7:0] b, logic present, logic fin, logic bad);
    u8vc_pkg::res_t r;
    r.out_byte     = b;
    r.byte_present = present;
    r.stream_end   = fin;
    r.status       = bad;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Step the UTF-8 decoder by one normalized byte; 0 means the text is invalid.
  function automatic logic decode_accepts(logic [7:0] v, logic fin);
    if (need == 2'd0) begin
      if (v == 8'h00 || (v < u8vc_pkg::CtlLimit && v != u8vc_pkg::ChLf &&
                         v != u8vc_pkg::ChTab) || v == u8vc_pkg::ChDel) return 1'b0;
      if (!v[7]) begin
        seq_len = 3'd1;
        acc     = {13'd0, v};
      end else if (v[7:5] == 3'b110) begin
        acc = {16'd0, v[4:0]};
        // C0 and C1 can only start overlong two-byte forms
        if (v[4:1] == 4'd0) return 1'b0;
        seq_len = 3'd2;
        need    = 2'd1;
      end else if (v[7:4] == 4'b1110) begin
        acc     = {17'd0, v[3:0]};
        seq_len = 3'd3;
        need    = 2'd2;
      end else if (v[7:3] == 5'b11110) begin
        acc     = {18'd0, v[2:0]};
        seq_len = 3'd4;
        need    = 2'd3;
      end else begin
        return 1'b0;
      end
    end else begin
      if (v[7:6] != 2'b10) return 1'b0;
      acc  = {acc[14:0], v[5:0]};
      need = need - 2'd1;
      if (need == 2'd0 &&
          ((seq_len == 3'd3 && acc < u8vc_pkg::Min3Byte) ||
           (seq_len == 3'd4 && acc < u8vc_pkg::Min4Byte) ||
           (acc >= u8vc_pkg::SurrLow && acc <= u8vc_pkg::SurrHigh) ||
           acc > u8vc_pkg::MaxCode)) return 1'b0;
    end
    return !(fin && need != 2'd0);
  endfunction

  function automatic void emit_normalized(logic [7:0] v, logic fin);
    if (decode_accepts(v, fin)) begin
      push_expected(v, 1'b1, fin, 1'b0);
    end else begin
      push_expected(8'h00, 1'b0, fin, 1'b1);
      bad_stream = 1'b1;
    end
    if (fin) reset_decoder();
  endfunction

  function automatic void predict_text_byte(logic [7:0] b, logic fin);
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == u8vc_pkg::ChLf) begin
        emit_normalized(u8vc_pkg::ChLf, fin);
        return;
      end
      emit_normalized(u8vc_pkg::ChLf, 1'b0);
    end
    // Drop everything after an error; only the stream end reports.
    if (bad_stream) begin
      if (fin) begin
        push_expected(8'h00, 1'b0, 1'b1, 1'b1);
        reset_decoder();
      end else begin
        dropped_bytes++;
      end
      return;
    end
    if (b == u8vc_pkg::ChCr) begin
      if (fin) emit_normalized(u8vc_pkg::ChLf, 1'b1);
      else cr_held = 1'b1;
      return;
    end
    emit_normalized(b, fin);
  endfunction

  function automatic void check_result();
    u8vc_pkg::res_t got;
    u8vc_pkg::res_t want;
    got.out_byte     = res_mon.out_byte;
    got.byte_present = res_mon.byte_present;
    got.stream_end   = res_mon.stream_end;
    got.status       = res_mon.status;
    results_seen++;
    if (got.stream_end) begin
      streams_seen++;
      if (got.status) bad_streams++;
    end
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected result byte=%02h present=%0b end=%0b status=%0b",
                 $realtime, got.out_byte, got.byte_present, got.stream_end, got.status);
      return;
    end
    want = expected_results.pop_front();
    if (got.out_byte != want.out_byte || got.byte_present != want.byte_present ||
        got.stream_end != want.stream_end || got.status != want.status) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: mismatch exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                 $realtime, want.out_byte, want.byte_present, want.stream_end, want.status,
                 got.out_byte, got.byte_present, got.stream_end, got.status);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      reset_decoder();
      fail_count    = 0;
      dropped_bytes = 0;
      results_seen  = 0;
      streams_seen  = 0;
      bad_streams   = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) check_result();
      if (text_mon.valid && text_mon.ready)
        predict_text_byte(text_mon.text_byte, text_mon.last_byte);
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/tb_utf8_validate_crlf_normalize.sv @@
`timescale 1ns / 100ps
// Testbench top: drives text streams into the validator under varying idling and gives the verdict.
module tb_utf8_validate_crlf_normalize;

  localparam int RandItems = 600;
  localparam int LongHold  = 60;
  // CycleLimit sits well above the slowest run (two results per byte, 53% receiver
  // idling, long hold).
  localparam int CycleLimit = 200000;
  localparam int unsigned BoundaryCodes [8] =
    '{'h80, 'h7FF, 'h800, 'hD7FF, 'hE000, 'hFFFF, 'h10000, 'h10FFFF};

  logic clk;
  logic rst;

  u8vc_in_if  text_in ();
  u8vc_out_if result_out ();

  int fail_count, pending, dropped_bytes, results_seen, streams_seen, bad_streams;
  int send_gap;
  int recv_gap;
  int phase_id;
  int bytes_sent = 0;
  int cycles     = 0;
  logic [7:0] stream_q[$];

  utf8_validate_crlf_normalize u_dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .result_out (result_out)
  );

  u8vc_scoreboard u_scoreboard (
    .clk           (clk),
    .rst           (rst),
    .text_mon      (text_in),
    .res_mon       (result_out),
    .fail_count    (fail_count),
    .pending       (pending),
    .dropped_bytes (dropped_bytes),
    .results_seen  (results_seen),
    .streams_seen  (streams_seen),
    .bad_streams   (bad_streams)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random back-pressure, and one long hold in the second phase.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    result_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_id == 1 && !hold_done) begin
        hold_done = 1'b1;
        result_out.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end else begin
        result_out.ready <= ($urandom_range(99) >= recv_gap);
      end
    end
  end

  // Enter and leave at a falling edge.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    logic taken;
    while ($urandom_range(99) < send_gap) begin
      text_in.valid <= 1'b0;
      @(negedge clk);
    end
    text_in.valid     <= 1'b1;
    text_in.text_byte <= b;
    text_in.last_byte <= fin;
    do begin
      @(posedge clk);
      taken = text_in.valid && text_in.ready;
      @(negedge clk);
    end while (!taken);
    bytes_sent++;
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++) push_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  task automatic drain_results();
    text_in.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  function automatic void add_byte(logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endfunction

  function automatic void put_cp(int unsigned cp);
    if (cp < 'h80) begin
      add_byte(8'(cp));
    end else if (cp < 'h800) begin
      add_byte(8'('hC0 | (cp >> 6)));
      add_byte(8'('h80 | (cp & 'h3F)));
    end else if (cp < 'h10000) begin
      add_byte(8'('hE0 | (cp >> 12)));
      add_byte(8'('h80 | ((cp >> 6) & 'h3F)));
      add_byte(8'('h80 | (cp & 'h3F)));
    end else begin
      add_byte(8'('hF0 | (cp >> 18)));
      add_byte(8'('h80 | ((cp >> 12) & 'h3F)));
      add_byte(8'('h80 | ((cp >> 6) & 'h3F)));
      add_byte(8'('h80 | (cp & 'h3F)));
    end
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range('h80, 'hBF));
  endfunction

  function automatic void put_good_char();
    int unsigned cp;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: put_cp($urandom_range('h20, 'h7E));
      4: add_byte(u8vc_pkg::ChLf);
      5: add_byte(u8vc_pkg::ChTab);
      6: add_byte(u8vc_pkg::ChCr);
      7: begin
        add_byte(u8vc_pkg::ChCr);
        add_byte(u8vc_pkg::ChLf);
      end
      8: put_cp($urandom_range('h80, 'h7FF));
      9: begin
        // skip the surrogate range
        cp = $urandom_range('h800, 'hF7FF);
        if (cp >= 'hD800) cp += 'h800;
        put_cp(cp);
      end
      10: put_cp($urandom_range('h10000, 'h10FFFF));
      default: put_cp(BoundaryCodes[$urandom_range(0, 7)]);
    endcase
  endfunction

  // Returns 1 when the chunk must end the stream (truncated sequence).
  function automatic bit put_bad_chunk();
    case ($urandom_range(0, 11))
      0: add_byte(8'($urandom_range(0, 255)));
      1: add_byte(8'($urandom_range(0, 'h1F)));
      2: add_byte(u8vc_pkg::ChDel);
      3: add_byte(cont_byte());
      4: begin
        add_byte(8'($urandom_range('hC0, 'hC1)));
        add_byte(cont_byte());
      end
      5: add_byte(8'($urandom_range('hF5, 'hFF)));
      6: begin
        add_byte(8'hE0);
        add_byte(8'($urandom_range('h80, 'h9F)));
        add_byte(cont_byte());
      end
      7: begin
        add_byte(8'hF0);
        add_byte(8'($urandom_range('h80, 'h8F)));
        add_byte(cont_byte());
        add_byte(cont_byte());
      end
      8: begin
        add_byte(8'hED);
        add_byte(8'($urandom_range('hA0, 'hBF)));
        add_byte(cont_byte());
      end
      9: begin
        add_byte(8'hF4);
        add_byte(8'($urandom_range('h90, 'hBF)));
        add_byte(cont_byte());
        add_byte(cont_byte());
      end
      10: begin
        case ($urandom_range(0, 2))
          0: add_byte(8'($urandom_range('hC2, 'hDF)));
          1: begin
            add_byte(8'($urandom_range('hE1, 'hEC)));
            if ($urandom_range(1)) add_byte(cont_byte());
          end
          default: begin
            add_byte(8'($urandom_range('hF1, 'hF3)));
            repeat ($urandom_range(0, 2)) add_byte(cont_byte());
          end
        endcase
        return 1'b1;
      end
      default: begin
        add_byte(8'($urandom_range('hC2, 'hF4)));
        add_byte(8'($urandom_range('h20, 'h7E)));
      end
    endcase
    return 1'b0;
  endfunction

  // Mostly well-formed text; a quarter of the streams carry one broken chunk.
  function automatic void build_stream();
    int chunks;
    int bad_at;
    chunks = $urandom_range(1, 6);
    bad_at = ($urandom_range(99) < 25) ? int'($urandom_range(0, chunks - 1)) : -1;
    for (int i = 0; i < chunks; i++) begin
      if (i == bad_at) begin
        if (put_bad_chunk()) break;
      end else begin
        put_good_char();
      end
    end
  endfunction

  initial begin
    int base;
    rst                 = 1'b1;
    phase_id            = -1;
    send_gap            = 20;
    recv_gap            = 53;
    text_in.valid       = 1'b0;
    text_in.text_byte   = 8'h00;
    text_in.last_byte   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // CR LF pair and TAB
    stream_q = '{8'h41, u8vc_pkg::ChCr, u8vc_pkg::ChLf, u8vc_pkg::ChTab};
    send_stream();
    // lone CR before a byte, CR as the final byte
    stream_q = '{u8vc_pkg::ChCr, 8'h7E, u8vc_pkg::ChCr};
    send_stream();
    stream_q = '{8'h00};
    send_stream();
    // two- and four-byte forms, then DEL and dropped bytes
    stream_q = '{8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80, u8vc_pkg::ChDel, 8'h41, 8'h42};
    send_stream();
    // sequence cut off by the stream end
    stream_q = '{8'hE2, 8'h82};
    send_stream();
    // held CR whose LF breaks an open sequence, on the final byte
    stream_q = '{8'hC3, u8vc_pkg::ChCr, 8'h20};
    send_stream();
    stream_q = '{8'hFF};
    send_stream();
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_gap = 20; recv_gap = 53; end
        1: begin send_gap = 53; recv_gap = 20; end
        default: begin send_gap = 0; recv_gap = 0; end
      endcase
      phase_id = phase;
      base = bytes_sent - dropped_bytes;
      while (bytes_sent - dropped_bytes - base < RandItems / 3) begin
        build_stream();
        send_stream();
      end
      drain_results();
    end

    repeat (8) @(negedge clk);
    $display("Sent %0d bytes in %0d streams (%0d reported invalid), %0d results checked.",
             bytes_sent, streams_seen, bad_streams, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/u8vc_pkg.sv
hdl/u8vc_in_if.sv
hdl/u8vc_out_if.sv
hdl/utf8_validate_crlf_normalize.sv
tb/u8vc_scoreboard.sv
tb/tb_utf8_validate_crlf_normalize.sv
